// ----- src/sab_pkg.sv -----
package sab_pkg;
    typedef enum logic [1:0] {
        FUNC_APPEND  = 2'd0,
        FUNC_RESTART = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;
    localparam int FUNC_W  = 2;
    localparam int LETTER_W = 8;
    localparam int STATE_W = 10;
    localparam int COUNT_W = 11;
endpackage

// ----- src/sab_if.sv -----
interface sab_in_if;
    import sab_pkg::*;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [LETTER_W-1:0] letter;
    modport source (output valid, func, letter, input ready);
    modport sink (input valid, func, letter, output ready);
endinterface

interface sab_out_if;
    import sab_pkg::*;
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] current_state;
    logic [COUNT_W-1:0] state_count;
    logic               full_res;
    modport source (output valid, current_state, state_count, full_res, input ready);
    modport sink (input valid, current_state, state_count, full_res, output ready);
endinterface

// ----- src/sab_ram.sv -----
module sab_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/suffix_automaton_builder_unit.sv -----
// Channel  Dir  Word
// in_ch    in   func, letter
// out_ch   out  current_state, state_count, full_res
// One word at a time; each memory access is a read state then a use state.
// Append: accept, read the end state (A0, A1), add a new state (NEW), walk the links
// (W0, W1 per step), check the length (Q0, Q1), latch the result (FIN). A clone adds
// C0 to C3, a row copy (CP0, then CP1 per letter) and R0, R1 per redirect step.
// After reset and after clear, a pass zeroes the tables one entry a cycle, over all
// 2**(SW+AW) slots (262144 by default); no word is taken then, only clear returns a word.
// The result waits in an output register; no new word is taken until it leaves.
module suffix_automaton_builder_unit #(
    parameter int MAX_STATES    = 1024,
    parameter int ALPHABET_SIZE = 256
) (
    input logic clk,
    input logic rst_n,
    sab_in_if.sink    in_ch,
    sab_out_if.source out_ch
);
    import sab_pkg::*;

    localparam int SW = $clog2(MAX_STATES);
    localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int TW = SW + AW;
    localparam int CW = SW + 1;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_A0, S_A1, S_NEW, S_W0, S_W1, S_Q0, S_Q1,
        S_C0, S_C1, S_C2, S_C3, S_CP0, S_CP1, S_R0, S_R1, S_FIN, S_OUT
    } st_t;

    st_t st_reg;
    logic [SW-1:0] p_reg, q_reg, nw_reg, cl_reg, cur_reg, lp_reg;
    logic [CW-1:0] used_reg;
    logic [AW-1:0] c_reg, k_reg;
    logic [TW-1:0] clr_reg;
    logic          gen_reg, full_reg, clr_out_reg;
    logic [SW-1:0] oc_reg;
    logic [CW-1:0] ou_reg;

    logic          t_we, l_we, k_we;
    logic [TW-1:0] t_wa, t_ra;
    logic [SW-1:0] t_wd, t_rd, l_wd, l_rd, k_wd, k_rd;
    logic [SW-1:0] l_wa, l_ra, k_wa, k_ra;

    sab_ram #(.WIDTH(SW), .DEPTH(1 << TW)) u_trans (
        .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
    sab_ram #(.WIDTH(SW), .DEPTH(1 << SW)) u_len (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    sab_ram #(.WIDTH(SW), .DEPTH(1 << SW)) u_link (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

    function automatic logic [TW-1:0] slot(input logic [SW-1:0] s, input logic [AW-1:0] c);
        slot = {s, c};
    endfunction

    always_comb
    begin
        t_we = 1'b0; t_wa = slot(p_reg, c_reg); t_wd = nw_reg; t_ra = slot(p_reg, c_reg);
        l_we = 1'b0; l_wa = nw_reg; l_wd = lp_reg + SW'(1); l_ra = p_reg;
        k_we = 1'b0; k_wa = nw_reg; k_wd = '0; k_ra = p_reg;
        unique case (st_reg)
            S_CLR:
            begin
                t_we = 1'b1; t_wa = clr_reg; t_wd = '0;
                l_we = 1'b1; l_wa = clr_reg[SW-1:0]; l_wd = '0;
                k_we = 1'b1; k_wa = clr_reg[SW-1:0]; k_wd = '0;
            end
            S_NEW: l_we = 1'b1;
            S_W1:
            begin
                if (t_rd == '0)
                begin
                    t_we = 1'b1;
                    if (p_reg == '0)
                    begin
                        k_we = 1'b1;
                    end
                end
            end
            S_Q0: l_ra = q_reg;
            S_Q1:
            begin
                if (!gen_reg && l_rd == lp_reg + SW'(1))
                begin
                    k_we = 1'b1; k_wd = q_reg;
                end
            end
            S_C0:
            begin
                l_we = 1'b1; l_wa = cl_reg;
                k_ra = q_reg;
            end
            S_C1:
            begin
                k_we = 1'b1; k_wa = cl_reg; k_wd = k_rd;
            end
            S_C2:
            begin
                k_we = 1'b1; k_wa = q_reg; k_wd = cl_reg;
            end
            S_C3:
            begin
                if (!gen_reg)
                begin
                    k_we = 1'b1; k_wd = cl_reg;
                end
            end
            S_CP0: t_ra = slot(q_reg, k_reg);
            S_CP1:
            begin
                t_we = 1'b1; t_wa = slot(cl_reg, k_reg); t_wd = t_rd;
                t_ra = slot(q_reg, k_reg + AW'(1));
            end
            S_R1:
            begin
                if (t_rd == q_reg)
                begin
                    t_we = 1'b1; t_wd = cl_reg;
                end
            end
            default: ;
        endcase
    end

    assign in_ch.ready          = (st_reg == S_IDLE);
    assign out_ch.valid         = (st_reg == S_OUT);
    assign out_ch.current_state = STATE_W'(oc_reg);
    assign out_ch.state_count   = COUNT_W'(ou_reg);
    assign out_ch.full_res      = full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_CLR;
            clr_reg     <= '0;
            clr_out_reg <= 1'b0;
            cur_reg     <= '0;
            used_reg    <= CW'(1);
            full_reg    <= 1'b0;
            gen_reg     <= 1'b0;
            p_reg       <= '0;
            q_reg       <= '0;
            nw_reg      <= '0;
            cl_reg      <= '0;
            lp_reg      <= '0;
            c_reg       <= '0;
            k_reg       <= '0;
            oc_reg      <= '0;
            ou_reg      <= CW'(1);
        end
        else
        begin
            unique case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + TW'(1);
                    if (clr_reg == '1)
                    begin
                        clr_out_reg <= 1'b0;
                        st_reg <= clr_out_reg ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        full_reg <= 1'b0;
                        p_reg <= cur_reg;
                        c_reg <= in_ch.letter[AW-1:0];
                        oc_reg <= cur_reg; ou_reg <= used_reg;
                        case (func_t'(in_ch.func))
                            FUNC_APPEND:
                            begin
                                if (CW'(MAX_STATES) - used_reg < CW'(2))
                                begin
                                    full_reg <= 1'b1; st_reg <= S_OUT;
                                end
                                else if (32'(in_ch.letter) >= ALPHABET_SIZE)
                                begin
                                    st_reg <= S_OUT;
                                end
                                else
                                begin
                                    st_reg <= S_A0;
                                end
                            end
                            FUNC_RESTART:
                            begin
                                cur_reg <= '0; oc_reg <= '0; st_reg <= S_OUT;
                            end
                            FUNC_CLEAR:
                            begin
                                cur_reg <= '0; used_reg <= CW'(1);
                                oc_reg <= '0; ou_reg <= CW'(1);
                                clr_reg <= '0; clr_out_reg <= 1'b1; st_reg <= S_CLR;
                            end
                            default: st_reg <= S_OUT;
                        endcase
                    end
                end
                S_A0: st_reg <= S_A1;
                S_A1:
                begin
                    lp_reg <= l_rd;
                    if (t_rd != '0)
                    begin
                        q_reg <= t_rd; gen_reg <= 1'b1; st_reg <= S_Q0;
                    end
                    else
                    begin
                        gen_reg <= 1'b0;
                        nw_reg <= used_reg[SW-1:0];
                        used_reg <= used_reg + CW'(1);
                        cur_reg <= used_reg[SW-1:0];
                        st_reg <= S_NEW;
                    end
                end
                S_NEW: st_reg <= S_W0;
                S_W0: st_reg <= S_W1;
                S_W1:
                begin
                    if (t_rd == '0)
                    begin
                        if (p_reg == '0)
                        begin
                            st_reg <= S_FIN;
                        end
                        else
                        begin
                            p_reg <= k_rd; st_reg <= S_W0;
                        end
                    end
                    else
                    begin
                        q_reg <= t_rd; lp_reg <= l_rd; st_reg <= S_Q0;
                    end
                end
                S_Q0: st_reg <= S_Q1;
                S_Q1:
                begin
                    if (l_rd == lp_reg + SW'(1))
                    begin
                        if (gen_reg)
                        begin
                            cur_reg <= q_reg;
                        end
                        st_reg <= S_FIN;
                    end
                    else
                    begin
                        cl_reg <= used_reg[SW-1:0];
                        used_reg <= used_reg + CW'(1);
                        if (gen_reg)
                        begin
                            cur_reg <= used_reg[SW-1:0];
                        end
                        st_reg <= S_C0;
                    end
                end
                S_C0: st_reg <= S_C1;
                S_C1: st_reg <= S_C2;
                S_C2: st_reg <= S_C3;
                S_C3:
                begin
                    k_reg <= '0; st_reg <= S_CP0;
                end
                S_CP0: st_reg <= S_CP1;
                S_CP1:
                begin
                    k_reg <= k_reg + AW'(1);
                    if (k_reg == '1)
                    begin
                        st_reg <= S_R0;
                    end
                end
                S_R0: st_reg <= S_R1;
                S_R1:
                begin
                    if (t_rd == q_reg && p_reg != '0)
                    begin
                        p_reg <= k_rd; st_reg <= S_R0;
                    end
                    else
                    begin
                        st_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    oc_reg <= cur_reg; ou_reg <= used_reg; st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
